@@ rtl/assert_macros.svh @@
// assertion macros shared by the estimator rtl
// depends on a clock named clk and an active-low reset named rst_n in the using module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define WSAE_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("check failed: %m");
`define WSAE_ASSERT_NEXT(lbl, cond, nxt) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) cond |=> nxt) else $error("check failed: %m");
`else
`define WSAE_ASSERT(lbl, prop)
`define WSAE_ASSERT_NEXT(lbl, cond, nxt)
`endif
`endif

@@ rtl/wsae_pkg.sv @@
// shared types, widths and codes of the windowed speed and acceleration estimator
// no dependencies
`default_nettype none

package wsae_pkg;

    localparam int WINDOW   = 16;
    localparam int HEAD_W   = $clog2(WINDOW);
    localparam int FILL_W   = $clog2(WINDOW + 1);
    localparam int STAMP_W  = 32;
    localparam int POS_W    = 16;
    localparam int RATE_W   = 32;
    localparam int PATH_W   = POS_W + 1 + HEAD_W;
    localparam int DSPD_W   = RATE_W + HEAD_W;
    localparam int US_W     = 20;
    localparam logic [US_W-1:0] US_PER_S = 20'd1000000;
    localparam int PROD_W   = DSPD_W + US_W;
    localparam int SMP_W    = STAMP_W + 2 * POS_W;
    localparam int SPD_W    = 2 * RATE_W;

    // ring read address select
    localparam logic [1:0] RD_P = 2'd0;
    localparam logic [1:0] RD_H = 2'd1;
    localparam logic [1:0] RD_N = 2'd2;

    // rate unit operand select
    localparam logic [1:0] SEL_SX = 2'd0;
    localparam logic [1:0] SEL_SY = 2'd1;
    localparam logic [1:0] SEL_AX = 2'd2;
    localparam logic [1:0] SEL_AY = 2'd3;

    typedef struct packed {
        logic [STAMP_W-1:0]      stamp_us;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
    } in_word_t;

    typedef struct packed {
        logic [RATE_W-1:0] speed_x;
        logic [RATE_W-1:0] speed_y;
        logic [RATE_W-1:0] accel_x;
        logic [RATE_W-1:0] accel_y;
        logic              speed_valid;
        logic              accel_valid;
    } out_word_t;

    typedef struct packed {
        logic       take_in;
        logic [1:0] rd_sel;
        logic       cap_p;
        logic       cap_h;
        logic       smp_upd;
        logic       spd_upd;
        logic       rate_start;
        logic [1:0] rate_sel;
        logic       rate_cap;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic speed_ok;
        logic accel_ok;
        logic rate_done;
        logic out_free;
    } sts_t;

    function automatic logic [HEAD_W-1:0] next_idx(input logic [HEAD_W-1:0] i);
        return (i == HEAD_W'(WINDOW - 1)) ? '0 : i + HEAD_W'(1);
    endfunction

    function automatic logic [HEAD_W-1:0] prev_idx(input logic [HEAD_W-1:0] i);
        return (i == '0) ? HEAD_W'(WINDOW - 1) : i - HEAD_W'(1);
    endfunction

endpackage

`default_nettype wire

@@ rtl/windowed_speed_accel_estimator.sv @@
// Windowed speed and acceleration estimator, top level.
// Input channel (in_valid, in_stall, in_word): one word is a microsecond stamp and
// signed Q12.4 x and y positions. Output channel (out_valid, out_stall, out_word):
// one word per input with x/y speed, x/y acceleration and their valid bits.
// A word moves at a rising edge with valid high and stall low.
// One input word is processed at a time: in_stall is high from the accepting edge
// until the result is loaded into the output register. Speed and acceleration take
// up to four passes of the shared rate unit (start, 20 shift-add multiply steps, one
// overflow check, 32 restoring divide steps, done), and each ring access costs three
// reads of a registered-read ram. A saturating pass skips the divide.
// The result sits in an output register; the next input is taken while it waits.
// A stalled receiver holds out_word steady and, once the next result is done,
// holds off further input until the output register frees up.
// Reset (rst_n, asynchronous, active low) empties both windows and clears all sums.
// depends on wsae_pkg, wsae_ctrl and wsae_datapath
`default_nettype none

module windowed_speed_accel_estimator (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire wsae_pkg::in_word_t   in_word,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output wsae_pkg::out_word_t       out_word
);

    wsae_pkg::cmd_t cmd;
    wsae_pkg::sts_t sts;

    // sequencer
    wsae_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // windows, arithmetic and output register
    wsae_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_word   (in_word),
        .cmd       (cmd),
        .sts       (sts),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_word  (out_word)
    );

endmodule

`default_nettype wire

@@ rtl/wsae_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module wsae_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ rtl/wsae_rate.sv @@
// rate unit: sum * 1e6 by serial shift-add, then restoring divide, saturating to 32 bits
// depends on wsae_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module wsae_rate (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [wsae_pkg::DSPD_W-1:0]  sum,
    input  wire logic [wsae_pkg::RATE_W-1:0]  den,
    output logic                              done,
    output logic      [wsae_pkg::RATE_W-1:0]  quo
);

    localparam int RW = wsae_pkg::RATE_W;
    localparam int PW = wsae_pkg::PROD_W;
    localparam int UW = wsae_pkg::US_W;
    localparam int RMW = RW + 1;

    localparam logic [1:0] R_IDLE = 2'd0;
    localparam logic [1:0] R_MUL  = 2'd1;
    localparam logic [1:0] R_CHK  = 2'd2;
    localparam logic [1:0] R_DIV  = 2'd3;

    logic [1:0]     st_reg, st_next;
    logic [4:0]     cnt_reg, cnt_next;
    logic [PW-1:0]  acc_reg, acc_next;
    logic [PW-1:0]  mcand_reg, mcand_next;
    logic [RW-1:0]  den_reg, den_next;
    logic [RMW-1:0] rem_reg, rem_next;
    logic [RW-1:0]  quo_reg, quo_next;
    logic           done_reg, done_next;

    logic [RMW-1:0] shifted;
    logic [PW-RW-1:0] acc_hi;

    assign acc_hi  = acc_reg[PW-1:RW];
    assign shifted = {rem_reg[RW-1:0], quo_reg[RW-1]};

    // multiply, overflow check and one quotient bit per cycle
    always_comb
    begin
        st_next    = st_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        mcand_next = mcand_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        done_next  = 1'b0;
        unique case (st_reg)
            R_IDLE:
            begin
                if (start)
                begin
                    st_next    = R_MUL;
                    cnt_next   = '0;
                    acc_next   = '0;
                    mcand_next = PW'(sum);
                    den_next   = den;
                end
            end
            R_MUL:
            begin
                if (wsae_pkg::US_PER_S[cnt_reg])
                begin
                    acc_next = acc_reg + mcand_reg;
                end
                mcand_next = {mcand_reg[PW-2:0], 1'b0};
                cnt_next   = cnt_reg + 5'd1;
                if (cnt_reg == 5'(UW - 1))
                begin
                    st_next = R_CHK;
                end
            end
            R_CHK:
            begin
                // quotient needs more than 32 bits when the high part reaches the divisor
                if (RMW'(acc_hi) >= {1'b0, den_reg})
                begin
                    quo_next  = '1;
                    st_next   = R_IDLE;
                    done_next = 1'b1;
                end
                else
                begin
                    rem_next = RMW'(acc_hi);
                    quo_next = acc_reg[RW-1:0];
                    cnt_next = '0;
                    st_next  = R_DIV;
                end
            end
            R_DIV:
            begin
                if (shifted >= {1'b0, den_reg})
                begin
                    rem_next = shifted - {1'b0, den_reg};
                    quo_next = {quo_reg[RW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = shifted;
                    quo_next = {quo_reg[RW-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(RW - 1))
                begin
                    st_next   = R_IDLE;
                    done_next = 1'b1;
                end
            end
            default:
            begin
                st_next = R_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= R_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            done_reg <= done_next;
        end
    end

    // arithmetic registers
    always_ff @(posedge clk)
    begin
        cnt_reg   <= cnt_next;
        acc_reg   <= acc_next;
        mcand_reg <= mcand_next;
        den_reg   <= den_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

    `WSAE_ASSERT(a_start_idle, start |-> st_reg == R_IDLE)

endmodule

`default_nettype wire

@@ rtl/wsae_datapath.sv @@
// datapath: sample and speed rings, window sums, rate unit and result registers
// depends on wsae_pkg, wsae_ram, wsae_rate and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module wsae_datapath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire wsae_pkg::in_word_t  in_word,
    input  wire wsae_pkg::cmd_t      cmd,
    output wsae_pkg::sts_t           sts,
    input  wire logic                out_stall,
    output logic                     out_valid,
    output wsae_pkg::out_word_t      out_word
);

    localparam int HW   = wsae_pkg::HEAD_W;
    localparam int FW   = wsae_pkg::FILL_W;
    localparam int TW   = wsae_pkg::STAMP_W;
    localparam int QW   = wsae_pkg::POS_W;
    localparam int RW   = wsae_pkg::RATE_W;
    localparam int PTW  = wsae_pkg::PATH_W;
    localparam int DW   = wsae_pkg::DSPD_W;
    localparam int SW   = wsae_pkg::SMP_W;
    localparam int VW   = wsae_pkg::SPD_W;
    localparam int WIN  = wsae_pkg::WINDOW;

    function automatic logic [QW:0] abs_pos(input logic [QW-1:0] a, input logic [QW-1:0] b);
        logic signed [QW:0] d;
        d = $signed({a[QW-1], a}) - $signed({b[QW-1], b});
        return d[QW] ? -d : d;
    endfunction

    function automatic logic [RW-1:0] abs_rate(input logic [RW-1:0] a, input logic [RW-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic logic [HW-1:0] sel_addr(input logic [HW-1:0] head, input logic [1:0] sel);
        logic [HW-1:0] a;
        unique case (sel)
            wsae_pkg::RD_P: a = wsae_pkg::prev_idx(head);
            wsae_pkg::RD_N: a = wsae_pkg::next_idx(head);
            default:        a = head;
        endcase
        return a;
    endfunction

    wsae_pkg::in_word_t  in_reg;
    wsae_pkg::out_word_t res_reg, res_next;
    wsae_pkg::out_word_t out_reg;
    logic                out_valid_reg;

    logic [SW-1:0]  smp_p_reg, smp_h_reg, smp_rd;
    logic [VW-1:0]  spd_p_reg, spd_h_reg, spd_rd;
    logic [FW-1:0]  sample_fill_reg, sample_fill_next;
    logic [FW-1:0]  speed_fill_reg, speed_fill_next;
    logic [HW-1:0]  write_head_reg, speed_head_reg;
    logic [TW-1:0]  elapsed_reg, elapsed_next;
    logic [PTW-1:0] path_x_reg, path_x_next, path_y_reg, path_y_next;
    logic [DW-1:0]  dspd_x_reg, dspd_x_next, dspd_y_reg, dspd_y_next;

    logic           s_have, s_full, v_have, v_full;
    logic [DW-1:0]  rate_sum;
    logic           rate_done;
    logic [RW-1:0]  rate_quo;

    // ring memories
    wsae_ram #(.WIDTH(SW), .DEPTH(WIN)) u_smp_ram (
        .clk     (clk),
        .wr_en   (cmd.smp_upd),
        .wr_addr (write_head_reg),
        .wr_data ({in_reg.stamp_us, in_reg.pos_x, in_reg.pos_y}),
        .rd_addr (sel_addr(write_head_reg, cmd.rd_sel)),
        .rd_data (smp_rd)
    );

    wsae_ram #(.WIDTH(VW), .DEPTH(WIN)) u_spd_ram (
        .clk     (clk),
        .wr_en   (cmd.spd_upd),
        .wr_addr (speed_head_reg),
        .wr_data ({res_reg.speed_x, res_reg.speed_y}),
        .rd_addr (sel_addr(speed_head_reg, cmd.rd_sel)),
        .rd_data (spd_rd)
    );

    // sample window sums: add newest step, drop oldest step when full
    assign s_have = (sample_fill_reg != '0);
    assign s_full = (sample_fill_reg == FW'(WIN));

    always_comb
    begin
        elapsed_next = elapsed_reg
            + (s_have ? in_reg.stamp_us - smp_p_reg[SW-1 -: TW] : '0)
            - (s_full ? smp_rd[SW-1 -: TW] - smp_h_reg[SW-1 -: TW] : '0);
        path_x_next = path_x_reg
            + (s_have ? PTW'(abs_pos(in_reg.pos_x, smp_p_reg[2*QW-1 -: QW])) : '0)
            - (s_full ? PTW'(abs_pos(smp_rd[2*QW-1 -: QW], smp_h_reg[2*QW-1 -: QW])) : '0);
        path_y_next = path_y_reg
            + (s_have ? PTW'(abs_pos(in_reg.pos_y, smp_p_reg[QW-1:0])) : '0)
            - (s_full ? PTW'(abs_pos(smp_rd[QW-1:0], smp_h_reg[QW-1:0])) : '0);
        sample_fill_next = s_full ? sample_fill_reg : sample_fill_reg + FW'(1);
    end

    // speed window sums
    assign v_have = (speed_fill_reg != '0);
    assign v_full = (speed_fill_reg == FW'(WIN));

    always_comb
    begin
        dspd_x_next = dspd_x_reg
            + (v_have ? DW'(abs_rate(res_reg.speed_x, spd_p_reg[VW-1 -: RW])) : '0)
            - (v_full ? DW'(abs_rate(spd_rd[VW-1 -: RW], spd_h_reg[VW-1 -: RW])) : '0);
        dspd_y_next = dspd_y_reg
            + (v_have ? DW'(abs_rate(res_reg.speed_y, spd_p_reg[RW-1:0])) : '0)
            - (v_full ? DW'(abs_rate(spd_rd[RW-1:0], spd_h_reg[RW-1:0])) : '0);
        speed_fill_next = v_full ? speed_fill_reg : speed_fill_reg + FW'(1);
    end

    // rate unit operand select
    always_comb
    begin
        unique case (cmd.rate_sel)
            wsae_pkg::SEL_SX: rate_sum = DW'(path_x_reg);
            wsae_pkg::SEL_SY: rate_sum = DW'(path_y_reg);
            wsae_pkg::SEL_AX: rate_sum = dspd_x_reg;
            default:          rate_sum = dspd_y_reg;
        endcase
    end

    wsae_rate u_rate (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.rate_start),
        .sum   (rate_sum),
        .den   (elapsed_reg),
        .done  (rate_done),
        .quo   (rate_quo)
    );

    // result capture
    always_comb
    begin
        res_next = res_reg;
        if (cmd.take_in)
        begin
            res_next = '0;
        end
        else if (cmd.rate_cap)
        begin
            unique case (cmd.rate_sel)
                wsae_pkg::SEL_SX:
                begin
                    res_next.speed_x     = rate_quo;
                    res_next.speed_valid = 1'b1;
                end
                wsae_pkg::SEL_SY: res_next.speed_y = rate_quo;
                wsae_pkg::SEL_AX:
                begin
                    res_next.accel_x     = rate_quo;
                    res_next.accel_valid = 1'b1;
                end
                default:          res_next.accel_y = rate_quo;
            endcase
        end
    end

    // window state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_fill_reg <= '0;
            speed_fill_reg  <= '0;
            write_head_reg  <= '0;
            speed_head_reg  <= '0;
            elapsed_reg     <= '0;
            path_x_reg      <= '0;
            path_y_reg      <= '0;
            dspd_x_reg      <= '0;
            dspd_y_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.smp_upd)
            begin
                sample_fill_reg <= sample_fill_next;
                write_head_reg  <= wsae_pkg::next_idx(write_head_reg);
                elapsed_reg     <= elapsed_next;
                path_x_reg      <= path_x_next;
                path_y_reg      <= path_y_next;
            end
            if (cmd.spd_upd)
            begin
                speed_fill_reg <= speed_fill_next;
                speed_head_reg <= wsae_pkg::next_idx(speed_head_reg);
                dspd_x_reg     <= dspd_x_next;
                dspd_y_reg     <= dspd_y_next;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.take_in)
        begin
            in_reg <= in_word;
        end
        if (cmd.cap_p)
        begin
            smp_p_reg <= smp_rd;
            spd_p_reg <= spd_rd;
        end
        if (cmd.cap_h)
        begin
            smp_h_reg <= smp_rd;
            spd_h_reg <= spd_rd;
        end
        if (cmd.out_load)
        begin
            out_reg <= res_reg;
        end
        res_reg <= res_next;
    end

    // status to the controller
    assign sts.speed_ok  = (sample_fill_reg > FW'(1)) && (elapsed_reg != '0);
    assign sts.accel_ok  = (speed_fill_reg > FW'(1));
    assign sts.rate_done = rate_done;
    assign sts.out_free  = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

    `WSAE_ASSERT(a_fill_order, speed_fill_reg <= sample_fill_reg)
    `WSAE_ASSERT(a_fill_max, sample_fill_reg <= FW'(WIN))

endmodule

`default_nettype wire

@@ rtl/wsae_ctrl.sv @@
// controller: sequences ring reads, window updates, up to four rate passes and output load
// depends on wsae_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module wsae_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire wsae_pkg::sts_t  sts,
    output wsae_pkg::cmd_t       cmd
);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_RD_P    = 5'd1;
    localparam logic [4:0] S_RD_H    = 5'd2;
    localparam logic [4:0] S_RD_N    = 5'd3;
    localparam logic [4:0] S_SUPD    = 5'd4;
    localparam logic [4:0] S_CHK     = 5'd5;
    localparam logic [4:0] S_SX_GO   = 5'd6;
    localparam logic [4:0] S_SX_WAIT = 5'd7;
    localparam logic [4:0] S_SY_GO   = 5'd8;
    localparam logic [4:0] S_SY_WAIT = 5'd9;
    localparam logic [4:0] S_VRD_P   = 5'd10;
    localparam logic [4:0] S_VRD_H   = 5'd11;
    localparam logic [4:0] S_VRD_N   = 5'd12;
    localparam logic [4:0] S_VUPD    = 5'd13;
    localparam logic [4:0] S_CHKA    = 5'd14;
    localparam logic [4:0] S_AX_GO   = 5'd15;
    localparam logic [4:0] S_AX_WAIT = 5'd16;
    localparam logic [4:0] S_AY_GO   = 5'd17;
    localparam logic [4:0] S_AY_WAIT = 5'd18;
    localparam logic [4:0] S_DONE    = 5'd19;

    logic [4:0] state_reg, state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = wsae_pkg::RD_N;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take_in = 1'b1;
                    state_next  = S_RD_P;
                end
            end
            S_RD_P:
            begin
                cmd.rd_sel = wsae_pkg::RD_P;
                state_next = S_RD_H;
            end
            S_RD_H:
            begin
                cmd.rd_sel = wsae_pkg::RD_H;
                cmd.cap_p  = 1'b1;
                state_next = S_RD_N;
            end
            S_RD_N:
            begin
                cmd.cap_h  = 1'b1;
                state_next = S_SUPD;
            end
            S_SUPD:
            begin
                cmd.smp_upd = 1'b1;
                state_next  = S_CHK;
            end
            S_CHK:
            begin
                state_next = sts.speed_ok ? S_SX_GO : S_DONE;
            end
            S_SX_GO:
            begin
                cmd.rate_sel   = wsae_pkg::SEL_SX;
                cmd.rate_start = 1'b1;
                state_next     = S_SX_WAIT;
            end
            S_SX_WAIT:
            begin
                cmd.rate_sel = wsae_pkg::SEL_SX;
                if (sts.rate_done)
                begin
                    cmd.rate_cap = 1'b1;
                    state_next   = S_SY_GO;
                end
            end
            S_SY_GO:
            begin
                cmd.rate_sel   = wsae_pkg::SEL_SY;
                cmd.rate_start = 1'b1;
                state_next     = S_SY_WAIT;
            end
            S_SY_WAIT:
            begin
                cmd.rate_sel = wsae_pkg::SEL_SY;
                if (sts.rate_done)
                begin
                    cmd.rate_cap = 1'b1;
                    state_next   = S_VRD_P;
                end
            end
            S_VRD_P:
            begin
                cmd.rd_sel = wsae_pkg::RD_P;
                state_next = S_VRD_H;
            end
            S_VRD_H:
            begin
                cmd.rd_sel = wsae_pkg::RD_H;
                cmd.cap_p  = 1'b1;
                state_next = S_VRD_N;
            end
            S_VRD_N:
            begin
                cmd.cap_h  = 1'b1;
                state_next = S_VUPD;
            end
            S_VUPD:
            begin
                cmd.spd_upd = 1'b1;
                state_next  = S_CHKA;
            end
            S_CHKA:
            begin
                state_next = sts.accel_ok ? S_AX_GO : S_DONE;
            end
            S_AX_GO:
            begin
                cmd.rate_sel   = wsae_pkg::SEL_AX;
                cmd.rate_start = 1'b1;
                state_next     = S_AX_WAIT;
            end
            S_AX_WAIT:
            begin
                cmd.rate_sel = wsae_pkg::SEL_AX;
                if (sts.rate_done)
                begin
                    cmd.rate_cap = 1'b1;
                    state_next   = S_AY_GO;
                end
            end
            S_AY_GO:
            begin
                cmd.rate_sel   = wsae_pkg::SEL_AY;
                cmd.rate_start = 1'b1;
                state_next     = S_AY_WAIT;
            end
            S_AY_WAIT:
            begin
                cmd.rate_sel = wsae_pkg::SEL_AY;
                if (sts.rate_done)
                begin
                    cmd.rate_cap = 1'b1;
                    state_next   = S_DONE;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    `WSAE_ASSERT_NEXT(a_accept_starts, in_valid && !in_stall, state_reg == S_RD_P)
    `WSAE_ASSERT(a_load_free, cmd.out_load |-> sts.out_free)

endmodule

`default_nettype wire

@@ test/windowed_speed_accel_estimator_tb.sv @@
// self-checking testbench of the windowed speed and acceleration estimator
// depends on wsae_pkg and windowed_speed_accel_estimator
`timescale 1ns / 1ps

module windowed_speed_accel_estimator_tb;

    localparam int N_RANDOM = 2000;
    localparam longint CYCLE_LIMIT = 64'd4000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    wsae_pkg::in_word_t in_word = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    wsae_pkg::out_word_t out_word;

    // predictor state
    logic [31:0] win_stamp [wsae_pkg::WINDOW];
    logic signed [15:0] win_px [wsae_pkg::WINDOW];
    logic signed [15:0] win_py [wsae_pkg::WINDOW];
    logic [31:0] win_sx [wsae_pkg::WINDOW];
    logic [31:0] win_sy [wsae_pkg::WINDOW];
    int unsigned smp_fill, spd_fill, smp_head, spd_head;
    logic [31:0] elapsed;
    logic [31:0] path_x, path_y;
    logic [63:0] dspd_x, dspd_y;

    wsae_pkg::out_word_t expected_words [$];
    longint cycles = 0;
    int mismatches = 0;
    int words_sent = 0;
    int words_seen = 0;
    int speeds_seen = 0;
    int accels_seen = 0;
    int sat_seen = 0;
    int stall_left = 0;

    windowed_speed_accel_estimator i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_word(in_word),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_word(out_word)
    );

    always #10 clk = ~clk;

    function automatic logic [31:0] pos_step(input logic signed [15:0] a,
                                             input logic signed [15:0] b);
        int d;
        d = int'(a) - int'(b);
        return (d < 0) ? -d : d;
    endfunction

    function automatic logic [31:0] rate_of(input logic [63:0] sum, input logic [31:0] dt);
        logic [127:0] q;
        q = (128'(sum) * 128'd1000000) / 128'(dt);
        return (q > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    endfunction

    function automatic logic [63:0] rate_step(input logic [31:0] a, input logic [31:0] b);
        return (a > b) ? 64'(a - b) : 64'(b - a);
    endfunction

    function automatic int unsigned wrap_next(input int unsigned i);
        return (i + 1 >= wsae_pkg::WINDOW) ? 0 : i + 1;
    endfunction

    function automatic int unsigned wrap_prev(input int unsigned i);
        return (i == 0) ? wsae_pkg::WINDOW - 1 : i - 1;
    endfunction

    // estimate the result word for one sample and advance the predictor state
    function automatic wsae_pkg::out_word_t estimate_motion(input wsae_pkg::in_word_t w);
        wsae_pkg::out_word_t r;
        int unsigned h, s, p, n;
        r = '0;
        h = smp_head;
        if (smp_fill > 0)
        begin
            p = wrap_prev(h);
            elapsed = elapsed + (w.stamp_us - win_stamp[p]);
            path_x = path_x + pos_step(w.pos_x, win_px[p]);
            path_y = path_y + pos_step(w.pos_y, win_py[p]);
        end
        if (smp_fill >= wsae_pkg::WINDOW)
        begin
            n = wrap_next(h);
            elapsed = elapsed - (win_stamp[n] - win_stamp[h]);
            path_x = path_x - pos_step(win_px[n], win_px[h]);
            path_y = path_y - pos_step(win_py[n], win_py[h]);
        end
        win_stamp[h] = w.stamp_us;
        win_px[h] = w.pos_x;
        win_py[h] = w.pos_y;
        smp_head = wrap_next(h);
        if (smp_fill < wsae_pkg::WINDOW) smp_fill++;
        if (smp_fill > 1 && elapsed != 0)
        begin
            s = spd_head;
            r.speed_x = rate_of(64'(path_x), elapsed);
            r.speed_y = rate_of(64'(path_y), elapsed);
            r.speed_valid = 1'b1;
            if (spd_fill > 0)
            begin
                p = wrap_prev(s);
                dspd_x = dspd_x + rate_step(r.speed_x, win_sx[p]);
                dspd_y = dspd_y + rate_step(r.speed_y, win_sy[p]);
            end
            if (spd_fill >= wsae_pkg::WINDOW)
            begin
                n = wrap_next(s);
                dspd_x = dspd_x - rate_step(win_sx[n], win_sx[s]);
                dspd_y = dspd_y - rate_step(win_sy[n], win_sy[s]);
            end
            win_sx[s] = r.speed_x;
            win_sy[s] = r.speed_y;
            spd_head = wrap_next(s);
            if (spd_fill < wsae_pkg::WINDOW) spd_fill++;
            if (spd_fill > 1)
            begin
                r.accel_x = rate_of(dspd_x, elapsed);
                r.accel_y = rate_of(dspd_y, elapsed);
                r.accel_valid = 1'b1;
            end
        end
        return r;
    endfunction

    // send one word after a random gap, queue its prediction on acceptance
    task automatic send_word(input wsae_pkg::in_word_t w, input logic has_fixed,
                             input wsae_pkg::out_word_t fixed);
        wsae_pkg::out_word_t pred;
        int gap;
        gap = $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        pred = estimate_motion(w);
        if (has_fixed && pred != fixed)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("table row disagrees with predictor: %h vs %h", fixed, pred);
        end
        expected_words.push_back(pred);
        words_sent++;
    endtask

    // sender goes quiet until every expected word has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge clk);
    endtask

    // receiver draws a random hold after every accepted word and stalls while it runs
    always @(posedge clk)
    begin
        int hold_left;
        hold_left = stall_left;
        if (out_valid && !out_stall)
            hold_left = $urandom_range(0, 8);
        else if (out_valid && hold_left > 0)
            hold_left--;
        stall_left <= hold_left;
        out_stall <= (hold_left > 0);
    end

    // compare each accepted result word with the oldest expectation
    always @(posedge clk)
    begin
        wsae_pkg::out_word_t exp_w;
        cycles <= cycles + 1;
        if (rst_n && out_valid && !out_stall)
        begin
            words_seen++;
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %h", out_word);
            end
            else
            begin
                exp_w = expected_words.pop_front();
                if (exp_w.speed_valid) speeds_seen++;
                if (exp_w.accel_valid) accels_seen++;
                if (exp_w.speed_x == 32'hFFFF_FFFF || exp_w.accel_x == 32'hFFFF_FFFF)
                    sat_seen++;
                if (out_word.speed_x !== exp_w.speed_x || out_word.speed_y !== exp_w.speed_y
                    || out_word.accel_x !== exp_w.accel_x
                    || out_word.accel_y !== exp_w.accel_y
                    || out_word.speed_valid !== exp_w.speed_valid
                    || out_word.accel_valid !== exp_w.accel_valid)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("word %0d: expected sx %h sy %h ax %h ay %h v %b%b, %s %h %h %h %h %b%b",
                                 words_seen, exp_w.speed_x, exp_w.speed_y, exp_w.accel_x,
                                 exp_w.accel_y, exp_w.speed_valid, exp_w.accel_valid,
                                 "got", out_word.speed_x, out_word.speed_y,
                                 out_word.accel_x, out_word.accel_y,
                                 out_word.speed_valid, out_word.accel_valid);
                end
            end
        end
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("windowed_speed_accel_estimator_tb NOT OK");
            $finish;
        end
    end

    // directed stimulus table
    typedef struct {
        wsae_pkg::in_word_t   w;
        logic                 has_fixed;
        wsae_pkg::out_word_t  fixed;
    } row_t;

    row_t rows [$];

    function automatic row_t mk_row(input logic [31:0] t, input logic [15:0] x,
                                    input logic [15:0] y, input logic has_fixed,
                                    input logic [31:0] sx, input logic [31:0] sy,
                                    input logic sv);
        row_t r;
        r.w.stamp_us = t;
        r.w.pos_x = x;
        r.w.pos_y = y;
        r.has_fixed = has_fixed;
        r.fixed = '0;
        r.fixed.speed_x = sx;
        r.fixed.speed_y = sy;
        r.fixed.speed_valid = sv;
        return r;
    endfunction

    initial
    begin
        wsae_pkg::in_word_t w;
        logic [31:0] t;
        logic signed [15:0] px, py;
        int mode, step;
        // first sample only stored, zero elapsed keeps nothing, extremes
        rows.push_back(mk_row(32'd0, 16'h8000, 16'h7FFF, 1'b1, 0, 0, 1'b0));
        rows.push_back(mk_row(32'd0, 16'h7FFF, 16'h8000, 1'b1, 0, 0, 1'b0));
        rows.push_back(mk_row(32'd1, 16'h8000, 16'h7FFF, 1'b0, 0, 0, 1'b0));
        rows.push_back(mk_row(32'd1000001, 16'h0000, 16'h0000, 1'b0, 0, 0, 1'b0));
        rows.push_back(mk_row(32'hFFFF_FFFF, 16'h7FFF, 16'h8000, 1'b0, 0, 0, 1'b0));
        rows.push_back(mk_row(32'd5, 16'h8000, 16'h0001, 1'b0, 0, 0, 1'b0));
        rows.push_back(mk_row(32'd5, 16'h0000, 16'hFFFF, 1'b0, 0, 0, 1'b0));
        for (int i = 0; i < 18; i++)
            rows.push_back(mk_row(32'd10 + 32'(i) * 32'd997, 16'(i * 1800), 16'(-i * 1700),
                                  1'b0, 0, 0, 1'b0));
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (rows[i]) send_word(rows[i].w, rows[i].has_fixed, rows[i].fixed);

        // sender holds off until every expected word has arrived
        drain_results();

        // random trajectories with occasional jumps and repeated stamps
        t = $urandom;
        px = 16'($urandom);
        py = 16'($urandom);
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i % 200 == 0) mode = $urandom_range(0, 3);
            case (mode)
                0: step = $urandom_range(1, 50);
                1: step = $urandom_range(0, 40000);
                2: step = $urandom_range(0, 3);
                default: step = $urandom;
            endcase
            t = t + 32'(step);
            if ($urandom_range(0, 9) == 0)
            begin
                px = 16'($urandom);
                py = 16'($urandom);
            end
            else
            begin
                px = px + 16'($signed($urandom_range(0, 400)) - 200);
                py = py + 16'($signed($urandom_range(0, 400)) - 200);
            end
            w.stamp_us = t;
            w.pos_x = px;
            w.pos_y = py;
            send_word(w, 1'b0, '0);
            if (i == N_RANDOM / 2)
                drain_results();
        end
        drain_results();
        repeat (300) @(posedge clk);
        $display("sent %0d samples, checked %0d words: %0d speeds, %0d accelerations",
                 words_sent, words_seen, speeds_seen, accels_seen);
        $display("saturated rates seen: %0d, mismatches: %0d", sat_seen, mismatches);
        if (mismatches == 0 && expected_words.size() == 0)
            $display("windowed_speed_accel_estimator_tb OK");
        else
            $display("windowed_speed_accel_estimator_tb NOT OK");
        $finish;
    end

endmodule
